// File: sv/grcs_pkg.sv
// Package for the group range change statistic block.
// Holds operation, status and register codes, the sequencer state type, the delta width and the transfer types.
`default_nettype none
package grcs_pkg;

  localparam int unsigned DeltaW = 48;

  typedef enum logic [1:0] {
    OP_COV_WRITE = 2'd0,
    OP_PERM_TOGGLE = 2'd1,
    OP_PROP_TOGGLE = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_IGNORED = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_ACTOR_COUNT = 2'd0,
    REG_FILTER_COUNT = 2'd1,
    REG_ALLOWED = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_ACC,
    S_SCAN_END,
    S_FLIP_RD,
    S_FLIP_WR,
    S_UNDO_RD,
    S_UNDO_WR,
    S_UNDO_FLIP,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [8:0]         tail_vertex;
    logic [8:0]         head_vertex;
    logic [7:0]         covariate_actor;
    logic signed [31:0] covariate_value;
    logic               last_in_proposal;
  } in_item_t;

  typedef struct packed {
    logic signed [DeltaW-1:0] delta_sum;
    logic                     proposal_done;
    logic [1:0]               status_code;
  } out_item_t;

endpackage
`default_nettype wire

// File: sv/grcs_stream_if.sv
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; payload type is a type parameter.
`default_nettype none
interface grcs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/group_range_change_statistic_top.sv
// Top level of the group range change statistic block.
// Depends on grcs_pkg and grcs_stream_if.
//
// Usage: in_if transfers one operation (covariate write, permanent toggle,
// proposal toggle); out_if transfers exactly one result per operation.
// Config is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i), written idle.
// After reset the block clears all 2**(AW+GW) bits of the membership memory
// (16384 at the default sizes), one bit a cycle, and only then raises in ready.
// A covariate write, or an ignored or overflowed toggle that does not end a
// proposal, goes straight to the output state; a permanent toggle first reads
// and writes back its bit. A proposal toggle scans the group's actor slots twice
// through the shared min/max/compare unit, before and after it flips the bit;
// each slot is read in S_SCAN_RD and folded in S_SCAN_ACC. The last toggle of a
// proposal replays the log, undoing each logged entry. One item is worked at a
// time. The result is loaded into the output register and in ready returns the
// next cycle; a result that finds the output register still held by a stalled
// receiver waits, and the next item waits behind it.
`default_nettype none
module group_range_change_statistic_top #(
  parameter int unsigned MAX_ACTORS = 256,
  parameter int unsigned MAX_GROUPS = 64,
  parameter int unsigned MAX_TOGGLES = 32,
  parameter int unsigned MAX_FILTER_SIZES = 4,
  parameter int unsigned COVARIATE_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [8:0]  cfg_data_i,
  grcs_stream_if.sink      in_if,
  grcs_stream_if.source    out_if
);
  localparam int unsigned AW = (MAX_ACTORS > 1) ? $clog2(MAX_ACTORS) : 1;
  localparam int unsigned GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned TW = $clog2(MAX_TOGGLES + 1);
  localparam int unsigned LW = (MAX_TOGGLES > 1) ? $clog2(MAX_TOGGLES) : 1;
  localparam int unsigned MW = AW + GW;
  localparam int unsigned CW = COVARIATE_WIDTH;
  localparam int unsigned DW = grcs_pkg::DeltaW;
  localparam int unsigned FW = $clog2(MAX_FILTER_SIZES + 1);
  localparam logic signed [DW-1:0] DMax = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMin = {1'b1, {(DW-1){1'b0}}};

  // config
  logic [8:0] actor_cnt_q;
  logic [2:0] filt_cnt_q;
  logic [8:0] allowed_q [MAX_FILTER_SIZES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      actor_cnt_q <= 9'd256;
      filt_cnt_q <= '0;
      for (int k = 0; k < MAX_FILTER_SIZES; k++) allowed_q[k] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 3'(grcs_pkg::REG_ACTOR_COUNT)) actor_cnt_q <= cfg_data_i;
      else if (cfg_idx_i == 3'(grcs_pkg::REG_FILTER_COUNT)) filt_cnt_q <= cfg_data_i[2:0];
      else if (cfg_idx_i >= 3'(grcs_pkg::REG_ALLOWED)) begin
        for (int k = 0; k < MAX_FILTER_SIZES; k++)
          if (32'(cfg_idx_i) == k + 32'(grcs_pkg::REG_ALLOWED)) allowed_q[k] <= cfg_data_i;
      end
    end
  end

  // effective actor count, clamped
  logic [12:0] na;
  always_comb begin
    if (actor_cnt_q == '0) na = 13'd1;
    else if (13'(actor_cnt_q) > 13'(MAX_ACTORS)) na = 13'(MAX_ACTORS);
    else na = 13'(actor_cnt_q);
  end

  logic [FW-1:0] nf;
  always_comb begin
    if (32'(filt_cnt_q) > MAX_FILTER_SIZES) nf = FW'(MAX_FILTER_SIZES);
    else nf = FW'(filt_cnt_q);
  end

  // endpoint resolution
  logic [8:0] tv, hv, av, gv;
  logic [13:0] gidx;
  logic res_ok;
  always_comb begin
    tv = in_if.data.tail_vertex;
    hv = in_if.data.head_vertex;
    av = (13'(tv) <= na) ? tv : hv;
    gv = (13'(tv) <= na) ? hv : tv;
    gidx = 14'(gv) - 14'(na) - 14'd1;
    res_ok = (13'(gv) > na) && (av != '0) && (13'(av) <= na)
           && (gidx < 14'(MAX_GROUPS));
  end

  logic cov_ok;
  assign cov_ok = 32'(in_if.data.covariate_actor) < MAX_ACTORS;

  // sequencer registers
  grcs_pkg::state_e st_q, st_d;
  logic [MW-1:0] clr_q;
  logic [MW-1:0] addr_q;
  logic [GW-1:0] grp_q;
  logic [AW:0]   slot_q;
  logic [AW:0]   ng_q;
  logic signed [CW-1:0] lo_q, hi_q;
  logic signed [CW:0] before_q;
  logic pass_q;
  logic [TW-1:0] len_q, undo_q;
  logic signed [DW-1:0] delta_q;
  logic last_q, prop_q;
  logic [1:0] status_q;
  logic out_valid_q, done_q;
  logic out_done_q;
  logic [1:0] out_status_q;
  logic signed [DW-1:0] shown_q;

  // memories
  logic mem_q [2**MW];
  logic [CW-1:0] cov_q [MAX_ACTORS];
  logic [MW-1:0] log_q [MAX_TOGGLES];
  logic mem_we, mem_wd, mem_rd_q;
  logic [MW-1:0] mem_wa, mem_ra;
  logic [CW-1:0] cov_rd_q;
  logic [AW-1:0] cov_ra;
  logic cov_we;
  logic log_we;
  logic [LW-1:0] log_ra;
  logic [MW-1:0] log_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    mem_rd_q <= mem_q[mem_ra];
    if (cov_we) cov_q[AW'(in_if.data.covariate_actor)] <=
      CW'(in_if.data.covariate_value);
    cov_rd_q <= cov_q[cov_ra];
    if (log_we) log_q[len_q[LW-1:0]] <= addr_q;
    log_rd_q <= log_q[log_ra];
  end

  logic size_ok;
  always_comb begin
    size_ok = (nf == '0);
    for (int k = 0; k < MAX_FILTER_SIZES; k++)
      if (FW'(k) < nf && 32'(allowed_q[k]) == 32'(ng_q)) size_ok = 1'b1;
  end

  logic signed [CW:0] contrib;
  assign contrib = (ng_q > 1 && size_ok) ? ((CW+1)'(hi_q) - (CW+1)'(lo_q)) : '0;

  logic signed [DW+1:0] sum;
  assign sum = (DW+2)'(delta_q) + (DW+2)'(contrib) - (DW+2)'(before_q);

  assign in_if.ready = (st_q == grcs_pkg::S_IDLE);
  logic acc;
  assign acc = in_if.valid && in_if.ready;
  logic out_load;
  assign out_load = (st_q == grcs_pkg::S_OUT) && (!out_valid_q || out_if.ready);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      grcs_pkg::S_CLEAR:
        if (clr_q == '1) st_d = grcs_pkg::S_IDLE;
      grcs_pkg::S_IDLE:
        if (acc) begin
          if (in_if.data.operation == grcs_pkg::OP_PROP_TOGGLE && res_ok &&
              32'(len_q) < MAX_TOGGLES) st_d = grcs_pkg::S_SCAN_RD;
          else if (in_if.data.operation == grcs_pkg::OP_PERM_TOGGLE && res_ok)
            st_d = grcs_pkg::S_FLIP_RD;
          else if (in_if.data.operation == grcs_pkg::OP_PROP_TOGGLE &&
                   in_if.data.last_in_proposal && len_q != '0)
            st_d = grcs_pkg::S_UNDO_RD;
          else st_d = grcs_pkg::S_OUT;
        end
      grcs_pkg::S_SCAN_RD: st_d = grcs_pkg::S_SCAN_ACC;
      grcs_pkg::S_SCAN_ACC:
        if (13'(slot_q) + 13'd1 >= na) st_d = grcs_pkg::S_SCAN_END;
        else st_d = grcs_pkg::S_SCAN_RD;
      grcs_pkg::S_SCAN_END:
        if (!pass_q) st_d = grcs_pkg::S_FLIP_RD;
        else if (last_q) st_d = grcs_pkg::S_UNDO_RD;
        else st_d = grcs_pkg::S_OUT;
      grcs_pkg::S_FLIP_RD: st_d = grcs_pkg::S_FLIP_WR;
      grcs_pkg::S_FLIP_WR:
        if (prop_q) st_d = grcs_pkg::S_SCAN_RD;
        else st_d = grcs_pkg::S_OUT;
      grcs_pkg::S_UNDO_RD: st_d = grcs_pkg::S_UNDO_WR;
      grcs_pkg::S_UNDO_WR: st_d = grcs_pkg::S_UNDO_FLIP;
      grcs_pkg::S_UNDO_FLIP:
        if (undo_q == TW'(1)) st_d = grcs_pkg::S_OUT;
        else st_d = grcs_pkg::S_UNDO_RD;
      grcs_pkg::S_OUT:
        if (out_load) st_d = grcs_pkg::S_IDLE;
      default: st_d = grcs_pkg::S_IDLE;
    endcase
  end

  // memory control
  logic [MW-1:0] undo_addr;
  assign undo_addr = log_rd_q;
  always_comb begin
    mem_we = 1'b0;
    mem_wd = 1'b0;
    mem_wa = addr_q;
    mem_ra = addr_q;
    cov_ra = slot_q[AW-1:0];
    cov_we = acc && in_if.data.operation == grcs_pkg::OP_COV_WRITE && cov_ok;
    log_we = 1'b0;
    log_ra = LW'(undo_q - TW'(1));
    unique case (st_q)
      grcs_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
      end
      grcs_pkg::S_SCAN_RD: mem_ra = MW'({grp_q, slot_q[AW-1:0]});
      grcs_pkg::S_FLIP_WR: begin
        mem_we = 1'b1;
        mem_wd = !mem_rd_q;
        log_we = prop_q;
      end
      grcs_pkg::S_UNDO_WR: mem_ra = undo_addr;
      grcs_pkg::S_UNDO_FLIP: begin
        mem_we = 1'b1;
        mem_wa = undo_addr;
        mem_wd = !mem_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= grcs_pkg::S_CLEAR;
      clr_q <= '0;
      addr_q <= '0;
      grp_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      before_q <= '0;
      len_q <= '0;
      undo_q <= '0;
      delta_q <= '0;
      out_valid_q <= 1'b0;
      done_q <= 1'b0;
      status_q <= grcs_pkg::ST_OK;
      out_done_q <= 1'b0;
      out_status_q <= grcs_pkg::ST_OK;
      shown_q <= '0;
      pass_q <= 1'b0;
      last_q <= 1'b0;
      prop_q <= 1'b0;
      slot_q <= '0;
      ng_q <= '0;
    end else begin
      st_q <= st_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
      unique case (st_q)
        grcs_pkg::S_CLEAR: clr_q <= clr_q + MW'(1);
        grcs_pkg::S_IDLE:
          if (acc) begin
            addr_q <= {gidx[GW-1:0], AW'(av - 9'd1)};
            grp_q <= gidx[GW-1:0];
            slot_q <= '0;
            ng_q <= '0;
            pass_q <= 1'b0;
            prop_q <= in_if.data.operation == grcs_pkg::OP_PROP_TOGGLE;
            last_q <= in_if.data.last_in_proposal;
            undo_q <= len_q;
            done_q <= in_if.data.operation == grcs_pkg::OP_PROP_TOGGLE &&
                      in_if.data.last_in_proposal;
            status_q <= grcs_pkg::ST_OK;
            unique case (in_if.data.operation) inside
              grcs_pkg::OP_COV_WRITE:
                if (!cov_ok) status_q <= grcs_pkg::ST_IGNORED;
              grcs_pkg::OP_PERM_TOGGLE, grcs_pkg::OP_PROP_TOGGLE:
                if (!res_ok) status_q <= grcs_pkg::ST_IGNORED;
                else if (in_if.data.operation == grcs_pkg::OP_PROP_TOGGLE &&
                         32'(len_q) >= MAX_TOGGLES) status_q <= grcs_pkg::ST_OVERFLOW;
              default: ;
            endcase
          end
        grcs_pkg::S_SCAN_ACC: begin
          if (mem_rd_q) begin
            if (ng_q == '0 || $signed(cov_rd_q) < lo_q) lo_q <= $signed(cov_rd_q);
            if (ng_q == '0 || $signed(cov_rd_q) > hi_q) hi_q <= $signed(cov_rd_q);
            ng_q <= ng_q + 1'b1;
          end
          slot_q <= slot_q + 1'b1;
        end
        grcs_pkg::S_SCAN_END: begin
          slot_q <= '0;
          ng_q <= '0;
          if (!pass_q) begin
            before_q <= contrib;
            pass_q <= 1'b1;
          end else begin
            if (sum > (DW+2)'(DMax)) delta_q <= DMax;
            else if (sum < (DW+2)'(DMin)) delta_q <= DMin;
            else delta_q <= DW'(sum);
            undo_q <= len_q;
          end
        end
        grcs_pkg::S_FLIP_WR: if (prop_q) len_q <= len_q + TW'(1);
        grcs_pkg::S_UNDO_FLIP: undo_q <= undo_q - TW'(1);
        grcs_pkg::S_OUT:
          if (out_load) begin
            shown_q <= delta_q;
            out_done_q <= done_q;
            out_status_q <= status_q;
            if (done_q) begin
              delta_q <= '0;
              len_q <= '0;
            end
          end
        default: ;
      endcase
    end
  end

  assign out_if.valid = out_valid_q;
  always_comb begin
    out_if.data = '0;
    out_if.data.delta_sum = shown_q;
    out_if.data.proposal_done = out_done_q;
    out_if.data.status_code = out_status_q;
  end

  ap_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= MAX_TOGGLES) else $error("log length past capacity");
  ap_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> st_q == grcs_pkg::S_IDLE) else $error("ready outside idle");
  ap_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && done_q) |=> len_q == '0 && delta_q == '0)
    else $error("proposal state not cleared");
endmodule
`default_nettype wire

// File: tb/sv/tb_group_range_change_statistic_top.sv
// Testbench for group_range_change_statistic_top: random and directed operations,
// checked against a predictor of membership, covariate ranges and proposal undo.
// Depends on grcs_pkg, grcs_stream_if and the top level.
`default_nettype none
module tb_group_range_change_statistic_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumActors = 256;
  localparam int unsigned NumGroups = 64;
  localparam int unsigned NumToggles = 32;
  localparam int unsigned NumSizes = 4;
  localparam int unsigned CycleLimit = 2000000;
  localparam longint DeltaHi = 64'sh7FFF_FFFF_FFFF;
  localparam longint DeltaLo = -DeltaHi - 1;

  class range_scoreboard;
    bit                 member [NumGroups][NumActors];
    logic signed [31:0] cov [NumActors];
    int unsigned        plog [NumToggles];
    int unsigned        plen;
    longint             delta;
    int unsigned        actor_cnt;
    int unsigned        filter_cnt;
    int unsigned        allowed [NumSizes];
    grcs_pkg::out_item_t results_q [$];
    int unsigned        errors;

    function new();
      foreach (member[g, a]) member[g][a] = 1'b0;
      foreach (cov[a]) cov[a] = '0;
      foreach (allowed[k]) allowed[k] = 0;
      plen = 0;
      delta = 0;
      actor_cnt = NumActors;
      filter_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [8:0] val);
      if (idx == 3'(grcs_pkg::REG_ACTOR_COUNT)) actor_cnt = val;
      else if (idx == 3'(grcs_pkg::REG_FILTER_COUNT)) filter_cnt = val[2:0];
      else if (idx >= 3'(grcs_pkg::REG_ALLOWED) &&
               idx < 3'(grcs_pkg::REG_ALLOWED) + NumSizes)
        allowed[idx - 3'(grcs_pkg::REG_ALLOWED)] = val;
    endfunction

    function int unsigned eff_actors();
      if (actor_cnt == 0) return 1;
      if (actor_cnt > NumActors) return NumActors;
      return actor_cnt;
    endfunction

    function bit size_ok(int unsigned ng);
      int unsigned n;
      n = (filter_cnt > NumSizes) ? NumSizes : filter_cnt;
      if (n == 0) return 1'b1;
      for (int unsigned k = 0; k < n; k++) if (allowed[k] == ng) return 1'b1;
      return 1'b0;
    endfunction

    function longint span_of(int unsigned g);
      longint lo, hi, c;
      int unsigned ng;
      lo = 0;
      hi = 0;
      ng = 0;
      for (int unsigned a = 0; a < eff_actors(); a++) begin
        if (member[g][a]) begin
          c = cov[a];
          if (ng == 0) begin
            lo = c;
            hi = c;
          end else begin
            if (c < lo) lo = c;
            if (c > hi) hi = c;
          end
          ng++;
        end
      end
      if (ng <= 1 || !size_ok(ng)) return 0;
      return hi - lo;
    endfunction

    function bit resolve(int unsigned t, int unsigned h, output int unsigned g,
                         output int unsigned a);
      int unsigned n1, av, gv;
      n1 = eff_actors();
      av = (t <= n1) ? t : h;
      gv = (t <= n1) ? h : t;
      g = 0;
      a = 0;
      if (gv <= n1) return 1'b0;
      if (av == 0 || av > n1) return 1'b0;
      if (gv - n1 - 1 >= NumGroups) return 1'b0;
      g = gv - n1 - 1;
      a = av - 1;
      return 1'b1;
    endfunction

    function void note(grcs_pkg::in_item_t it);
      grcs_pkg::out_item_t r;
      int unsigned g, a, e;
      longint      b4, s;
      bit          done, ok;
      logic [1:0]  st;
      done = 1'b0;
      st = grcs_pkg::ST_OK;
      case (it.operation)
        grcs_pkg::OP_COV_WRITE: begin
          cov[it.covariate_actor] = it.covariate_value;
        end
        grcs_pkg::OP_PERM_TOGGLE: begin
          ok = resolve(it.tail_vertex, it.head_vertex, g, a);
          if (ok) member[g][a] ^= 1'b1;
          else st = grcs_pkg::ST_IGNORED;
        end
        grcs_pkg::OP_PROP_TOGGLE: begin
          ok = resolve(it.tail_vertex, it.head_vertex, g, a);
          if (!ok) begin
            st = grcs_pkg::ST_IGNORED;
          end else if (plen >= NumToggles) begin
            st = grcs_pkg::ST_OVERFLOW;
          end else begin
            b4 = span_of(g);
            member[g][a] ^= 1'b1;
            s = delta + span_of(g) - b4;
            delta = (s > DeltaHi) ? DeltaHi : (s < DeltaLo) ? DeltaLo : s;
            plog[plen] = g * NumActors + a;
            plen++;
          end
          if (it.last_in_proposal) begin
            for (int k = int'(plen) - 1; k >= 0; k--) begin
              e = plog[k];
              member[(e / NumActors) % NumGroups][e % NumActors] ^= 1'b1;
            end
            done = 1'b1;
          end
        end
        default: ;
      endcase
      r.delta_sum = delta[grcs_pkg::DeltaW-1:0];
      r.proposal_done = done;
      r.status_code = st;
      if (done) begin
        delta = 0;
        plen = 0;
      end
      results_q.push_back(r);
    endfunction

    function void check(grcs_pkg::out_item_t got);
      grcs_pkg::out_item_t want;
      if (results_q.size() == 0) begin
        $error("unexpected result delta_sum %0d", got.delta_sum);
        errors++;
        return;
      end
      want = results_q.pop_front();
      if (got.delta_sum !== want.delta_sum) begin
        $error("delta_sum expected %0d actual %0d", want.delta_sum, got.delta_sum);
        errors++;
      end
      if (got.proposal_done !== want.proposal_done) begin
        $error("proposal_done expected %0d actual %0d", want.proposal_done,
               got.proposal_done);
        errors++;
      end
      if (got.status_code !== want.status_code) begin
        $error("status_code expected %0d actual %0d", want.status_code,
               got.status_code);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return results_q.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic [8:0] cfg_data;
  bit         calm;
  bit         hold_req;
  int unsigned cycles;
  int unsigned na;
  range_scoreboard sb;

  grcs_stream_if #(.T(grcs_pkg::in_item_t))  in_ch ();
  grcs_stream_if #(.T(grcs_pkg::out_item_t)) out_ch ();

  group_range_change_statistic_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check(out_ch.data);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (399) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [8:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    na = sb.eff_actors();
  endtask

  task automatic push_item(grcs_pkg::in_item_t it);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic grcs_pkg::in_item_t mk(grcs_pkg::op_e op, int unsigned t,
                                            int unsigned h, bit last);
    grcs_pkg::in_item_t it;
    it.operation = op;
    it.tail_vertex = t[8:0];
    it.head_vertex = h[8:0];
    it.covariate_actor = 8'($urandom);
    it.covariate_value = $urandom;
    it.last_in_proposal = last;
    return it;
  endfunction

  function automatic grcs_pkg::in_item_t edge_item(grcs_pkg::op_e op, bit last);
    int unsigned a, k;
    a = $urandom_range(1, na);
    k = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(0, 63);
    if ($urandom_range(0, 1)) return mk(op, a, na + 1 + k, last);
    return mk(op, na + 1 + k, a, last);
  endfunction

  task automatic run_random(int unsigned n);
    int unsigned cnt, len, r;
    grcs_pkg::in_item_t it;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        it = mk(grcs_pkg::OP_COV_WRITE, 1, 1, $urandom_range(0, 1));
        push_item(it);
        cnt++;
      end else if (r < 18) begin
        push_item(edge_item(grcs_pkg::OP_PERM_TOGGLE, $urandom_range(0, 1)));
        cnt++;
      end else if (r < 24) begin
        it = mk(grcs_pkg::op_e'($urandom_range(0, 3)), $urandom_range(0, 511),
                $urandom_range(0, 511), $urandom_range(0, 1));
        push_item(it);
        cnt++;
      end else begin
        len = ($urandom_range(0, 99) < 5) ? $urandom_range(33, 36) : $urandom_range(1, 5);
        for (int unsigned i = 1; i <= len; i++) begin
          if ($urandom_range(0, 99) < 5)
            it = mk(grcs_pkg::OP_PROP_TOGGLE, $urandom_range(0, 511),
                    $urandom_range(0, 511), i == len);
          else
            it = edge_item(grcs_pkg::OP_PROP_TOGGLE, i == len);
          push_item(it);
          cnt++;
        end
      end
    end
    drain();
  endtask

  initial begin
    grcs_pkg::in_item_t it;
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    na = NumActors;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // write every covariate so no unwritten entry is ever read
    for (int unsigned a = 0; a < NumActors; a++) begin
      it = mk(grcs_pkg::OP_COV_WRITE, 1, 1, 1'b0);
      it.covariate_actor = a[7:0];
      if (a == 0) it.covariate_value = 32'sh8000_0000;
      else if (a == 1 || a == 255) it.covariate_value = 32'sh7FFF_FFFF;
      else if (a == 2) it.covariate_value = '0;
      else if (a == 3) it.covariate_value = -32'sd1;
      push_item(it);
    end

    push_item(mk(grcs_pkg::OP_PERM_TOGGLE, 1, 257, 1'b0));
    push_item(mk(grcs_pkg::OP_PERM_TOGGLE, 257, 2, 1'b1));
    push_item(mk(grcs_pkg::OP_PROP_TOGGLE, 3, 257, 1'b0));
    push_item(mk(grcs_pkg::OP_PROP_TOGGLE, 256, 320, 1'b0));
    push_item(mk(grcs_pkg::OP_PROP_TOGGLE, 4, 257, 1'b0));
    push_item(mk(grcs_pkg::OP_PROP_TOGGLE, 0, 257, 1'b0));
    push_item(mk(grcs_pkg::OP_PROP_TOGGLE, 1, 2, 1'b0));
    push_item(mk(grcs_pkg::OP_PROP_TOGGLE, 257, 320, 1'b0));
    push_item(mk(grcs_pkg::OP_PROP_TOGGLE, 1, 321, 1'b0));
    push_item(mk(grcs_pkg::OP_PROP_TOGGLE, 1, 257, 1'b1));
    push_item(mk(grcs_pkg::OP_COV_WRITE, 1, 1, 1'b1));
    push_item(mk(grcs_pkg::OP_UNUSED, 1, 257, 1'b1));
    push_item(mk(grcs_pkg::OP_PROP_TOGGLE, 511, 1, 1'b1));
    push_item(mk(grcs_pkg::OP_PERM_TOGGLE, 0, 0, 1'b0));
    push_item(mk(grcs_pkg::OP_PERM_TOGGLE, 320, 255, 1'b0));
    push_item(mk(grcs_pkg::OP_PROP_TOGGLE, 255, 320, 1'b1));
    drain();

    cfg_write(3'(grcs_pkg::REG_ACTOR_COUNT), 9'd0);
    cfg_write(3'(grcs_pkg::REG_FILTER_COUNT), 9'd4);
    cfg_write(3'(grcs_pkg::REG_ALLOWED), 9'd0);
    cfg_write(3'(grcs_pkg::REG_ALLOWED) + 3'd1, 9'd256);
    cfg_write(3'(grcs_pkg::REG_ALLOWED) + 3'd2, 9'd1);
    cfg_write(3'(grcs_pkg::REG_ALLOWED) + 3'd3, 9'd2);
    run_random(60);

    cfg_write(3'(grcs_pkg::REG_ACTOR_COUNT), 9'd8);
    cfg_write(3'(grcs_pkg::REG_FILTER_COUNT), 9'd0);
    run_random(400);

    cfg_write(3'(grcs_pkg::REG_ACTOR_COUNT), 9'd6);
    cfg_write(3'(grcs_pkg::REG_FILTER_COUNT), 9'd2);
    cfg_write(3'(grcs_pkg::REG_ALLOWED), 9'd2);
    cfg_write(3'(grcs_pkg::REG_ALLOWED) + 3'd1, 9'd3);
    hold_req = 1'b1;
    run_random(150);
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;
    run_random(100);

    cfg_write(3'(grcs_pkg::REG_ACTOR_COUNT), 9'd12);
    cfg_write(3'(grcs_pkg::REG_FILTER_COUNT), 9'd7);
    cfg_write(3'(grcs_pkg::REG_ALLOWED), 9'd4);
    cfg_write(3'(grcs_pkg::REG_ALLOWED) + 3'd1, 9'd5);
    cfg_write(3'(grcs_pkg::REG_ALLOWED) + 3'd2, 9'd2);
    cfg_write(3'(grcs_pkg::REG_ALLOWED) + 3'd3, 9'd256);
    run_random(400);

    cfg_write(3'(grcs_pkg::REG_ACTOR_COUNT), 9'd511);
    cfg_write(3'(grcs_pkg::REG_FILTER_COUNT), 9'd1);
    cfg_write(3'(grcs_pkg::REG_ALLOWED), 9'd3);
    run_random(60);

    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      if (sb.pending() != 0) $error("results still outstanding: %0d", sb.pending());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
